### rtl/core/gwsp_pkg.sv
// shared constants and types of the grid wave shortest path unit
package gwsp_pkg;

  localparam int MAX_COLS_DEF = 8;
  localparam int MAX_ROWS_DEF = 8;

  localparam int LABEL_W    = 7;
  localparam int STEP_W     = 6;
  localparam int MAX_STEP   = 63;
  localparam int PATH_DEPTH = MAX_STEP + 1;
  localparam int ADDR_W_MAX = 12;

  localparam logic [LABEL_W-1:0] UNLABELLED = 7'd127;

  // neighbour order for wave and trace
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_SOLVE = 1'b1;

  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  // access request from the sequencer to the grid store
  typedef struct packed {
    logic [ADDR_W_MAX-1:0] rd_addr;
    logic [ADDR_W_MAX-1:0] wr_addr;
    logic                  blk_we;
    logic                  blk_wd;
    logic                  lab_we;
    logic [LABEL_W-1:0]    lab_wd;
  } grid_req_t;

endpackage

### rtl/core/gwsp_grid_store.sv
// blocked map and distance label memories with post-reset clearing pass
module gwsp_grid_store #(
  parameter int MAX_COLS = gwsp_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gwsp_pkg::MAX_ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gwsp_pkg::grid_req_t          req,
  output logic                         busy,
  output logic                         blk_rd,
  output logic [gwsp_pkg::LABEL_W-1:0] lab_rd
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);

  logic                         blk_mem [CELLS];
  logic [gwsp_pkg::LABEL_W-1:0] lab_mem [CELLS];

  logic                         clr_busy_r;
  logic [AW-1:0]                clr_addr_r;
  logic                         blk_rd_r;
  logic [gwsp_pkg::LABEL_W-1:0] lab_rd_r;

  logic [AW-1:0] ra;
  logic [AW-1:0] wa;

  assign ra = req.rd_addr[AW-1:0];
  assign wa = req.wr_addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(CELLS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // blocked map: clearing pass owns the write port while busy
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      blk_mem[clr_addr_r] <= 1'b0;
    end else if (req.blk_we) begin
      blk_mem[wa] <= req.blk_wd;
    end
    blk_rd_r <= blk_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (req.lab_we) begin
      lab_mem[wa] <= req.lab_wd;
    end
    lab_rd_r <= lab_mem[ra];
  end

  assign busy   = clr_busy_r;
  assign blk_rd = blk_rd_r;
  assign lab_rd = lab_rd_r;

endmodule

### rtl/core/gwsp_path_store.sv
// path buffer, written goal to start during trace and read start to goal
module gwsp_path_store #(
  parameter int MAX_COLS = gwsp_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gwsp_pkg::MAX_ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [gwsp_pkg::STEP_W-1:0] wr_idx,
  input  logic [$clog2(MAX_ROWS)-1:0] wr_row,
  input  logic [$clog2(MAX_COLS)-1:0] wr_col,
  input  logic [gwsp_pkg::STEP_W-1:0] rd_idx,
  output logic [$clog2(MAX_ROWS)-1:0] rd_row,
  output logic [$clog2(MAX_COLS)-1:0] rd_col
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CWD = $clog2(MAX_COLS);

  logic [RW+CWD-1:0] path_mem [gwsp_pkg::PATH_DEPTH];
  logic [RW+CWD-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      path_mem[wr_idx] <= {wr_row, wr_col};
    end
    rd_data_r <= path_mem[rd_idx];
  end

  assign rd_row = rd_data_r[RW+CWD-1:CWD];
  assign rd_col = rd_data_r[CWD-1:0];

endmodule

### rtl/core/grid_wave_shortest_path_unit.sv
// top level of the grid wave shortest path unit: sequencer, config and result register
//
// usage
// - input channel (in_valid / in_ready): a load transaction (in_action = 0) writes
//   one cell's blocked bit and gives no result; a solve transaction
//   (in_action = 1) gives start and goal cells and yields a stream of results
// - result channel (out_valid / out_ready): path cells from start to goal, with
//   out_last on the goal cell; a single out_outcome = 1 result when there is no way
// - cfg_we / cfg_index / cfg_wdata set the grid width and height in use; write
//   only while the unit is idle
// - one solve is handled at a time; in_ready is high only when idle
// - a solve runs an endpoint check, then the label clear and seed, then per wave
//   layer a pass over each cell in use (one label memory read port, one read per
//   neighbour), then the trace of the path, then the emission of the results
// - after reset the blocked map is swept free with in_ready low; config writes
//   are taken during the sweep
// - a stalled receiver holds the result register; the sequencer waits on it
module grid_wave_shortest_path_unit #(
  parameter int MAX_COLS = gwsp_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = gwsp_pkg::MAX_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic [2:0] in_cell_row,
  input  logic [2:0] in_cell_col,
  input  logic       in_blocked,
  input  logic [2:0] in_start_row,
  input  logic [2:0] in_start_col,
  input  logic [2:0] in_goal_row,
  input  logic [2:0] in_goal_col,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_path_row,
  output logic [2:0] out_path_col,
  output logic [5:0] out_step_number,
  output logic       out_outcome,
  output logic       out_last,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [3:0] cfg_wdata
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CWD   = $clog2(MAX_COLS);
  localparam int SW    = gwsp_pkg::STEP_W;
  localparam int LW    = gwsp_pkg::LABEL_W;

  // sequencer states
  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_EP_S    = 5'd1;
  localparam logic [4:0] ST_EP_SD   = 5'd2;
  localparam logic [4:0] ST_EP_GD   = 5'd3;
  localparam logic [4:0] ST_CLR     = 5'd4;
  localparam logic [4:0] ST_SEED    = 5'd5;
  localparam logic [4:0] ST_W_SELF  = 5'd6;
  localparam logic [4:0] ST_W_SELFD = 5'd7;
  localparam logic [4:0] ST_W_NB    = 5'd8;
  localparam logic [4:0] ST_W_NBD   = 5'd9;
  localparam logic [4:0] ST_W_NEXT  = 5'd10;
  localparam logic [4:0] ST_T_STORE = 5'd11;
  localparam logic [4:0] ST_T_NB    = 5'd12;
  localparam logic [4:0] ST_T_NBD   = 5'd13;
  localparam logic [4:0] ST_E_RD    = 5'd14;
  localparam logic [4:0] ST_E_OUT   = 5'd15;
  localparam logic [4:0] ST_NOWAY   = 5'd16;

  // row-major cell address
  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CWD-1:0] c);
    cell_addr = AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  // size register: zero acts as one, above the maximum acts as the maximum
  function automatic logic [3:0] clamp_size(input logic [3:0] v, input int max_v);
    if (v == 4'd0) begin
      clamp_size = 4'd1;
    end else if (int'(v) > max_v) begin
      clamp_size = 4'(max_v);
    end else begin
      clamp_size = v;
    end
  endfunction

  logic [3:0] cols_in_use_r;
  logic [3:0] rows_in_use_r;

  logic [4:0]     state_r, state_nxt;
  logic [RW-1:0]  r_r, r_nxt;     // scan cell in wave, current cell in trace
  logic [CWD-1:0] c_r, c_nxt;
  logic [1:0]     k_r, k_nxt;     // neighbour direction
  logic [SW-1:0]  d_r, d_nxt;     // wave layer
  logic [SW-1:0]  td_r, td_nxt;   // trace distance
  logic [SW-1:0]  len_r, len_nxt;
  logic [SW-1:0]  i_r, i_nxt;     // emission index
  logic           grew_r, grew_nxt;
  logic           hit_r, hit_nxt;
  logic [AW-1:0]  sweep_r, sweep_nxt;
  logic [RW-1:0]  sr_r, sr_nxt, gr_r, gr_nxt;
  logic [CWD-1:0] sc_r, sc_nxt, gc_r, gc_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_row_r, out_row_nxt;
  logic [2:0] out_col_r, out_col_nxt;
  logic [5:0] out_step_r, out_step_nxt;
  logic       out_outcome_r, out_outcome_nxt;
  logic       out_last_r, out_last_nxt;

  logic [3:0]     w, h;
  logic [7:0]     w8, h8;
  logic           nb_ok;
  logic [RW-1:0]  nb_r;
  logic [CWD-1:0] nb_c;
  logic           out_free;
  logic           clr_busy;
  logic           blk_rd;
  logic [LW-1:0]  lab_rd;
  logic [RW-1:0]  p_row;
  logic [CWD-1:0] p_col;
  logic           path_we;
  logic [AW-1:0]  rd_addr, wr_addr;
  gwsp_pkg::grid_req_t req;

  assign w  = clamp_size(cols_in_use_r, MAX_COLS);
  assign h  = clamp_size(rows_in_use_r, MAX_ROWS);
  assign w8 = 8'(w);
  assign h8 = 8'(h);

  assign in_ready = (state_r == ST_IDLE) && !clr_busy;
  assign out_free = !out_valid_r || out_ready;

  // neighbour of the current cell in direction k
  always_comb begin
    nb_r  = r_r;
    nb_c  = c_r;
    nb_ok = 1'b0;
    case (k_r)
      gwsp_pkg::DIR_RIGHT: begin
        nb_c  = c_r + CWD'(1);
        nb_ok = (8'(c_r) + 8'd1) < w8;
      end
      gwsp_pkg::DIR_DOWN: begin
        nb_r  = r_r + RW'(1);
        nb_ok = (8'(r_r) + 8'd1) < h8;
      end
      gwsp_pkg::DIR_LEFT: begin
        nb_c  = c_r - CWD'(1);
        nb_ok = c_r != '0;
      end
      gwsp_pkg::DIR_UP: begin
        nb_r  = r_r - RW'(1);
        nb_ok = r_r != '0;
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  // grid store read address, data returns on the next cycle
  always_comb begin
    case (state_r)
      ST_EP_S:           rd_addr = cell_addr(sr_r, sc_r);
      ST_EP_SD:          rd_addr = cell_addr(gr_r, gc_r);
      ST_W_NB, ST_T_NB:  rd_addr = cell_addr(nb_r, nb_c);
      default:           rd_addr = cell_addr(r_r, c_r);
    endcase
  end

  // main sequencer
  always_comb begin
    state_nxt       = state_r;
    r_nxt           = r_r;
    c_nxt           = c_r;
    k_nxt           = k_r;
    d_nxt           = d_r;
    td_nxt          = td_r;
    len_nxt         = len_r;
    i_nxt           = i_r;
    grew_nxt        = grew_r;
    hit_nxt         = hit_r;
    sweep_nxt       = sweep_r;
    sr_nxt          = sr_r;
    sc_nxt          = sc_r;
    gr_nxt          = gr_r;
    gc_nxt          = gc_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_row_nxt     = out_row_r;
    out_col_nxt     = out_col_r;
    out_step_nxt    = out_step_r;
    out_outcome_nxt = out_outcome_r;
    out_last_nxt    = out_last_r;
    wr_addr         = cell_addr(r_r, c_r);
    req.blk_we      = 1'b0;
    req.blk_wd      = in_blocked;
    req.lab_we      = 1'b0;
    req.lab_wd      = gwsp_pkg::UNLABELLED;
    path_we         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_action == gwsp_pkg::ACT_LOAD) begin
            // loads outside the storage are dropped
            if ((int'(in_cell_row) < MAX_ROWS) && (int'(in_cell_col) < MAX_COLS)) begin
              wr_addr    = cell_addr(RW'(in_cell_row), CWD'(in_cell_col));
              req.blk_we = 1'b1;
            end
          end else begin
            sr_nxt = RW'(in_start_row);
            sc_nxt = CWD'(in_start_col);
            gr_nxt = RW'(in_goal_row);
            gc_nxt = CWD'(in_goal_col);
            if ((8'(in_start_row) >= h8) || (8'(in_start_col) >= w8) ||
                (8'(in_goal_row) >= h8) || (8'(in_goal_col) >= w8)) begin
              state_nxt = ST_NOWAY;
            end else begin
              state_nxt = ST_EP_S;
            end
          end
        end
      end
      ST_EP_S: begin
        state_nxt = ST_EP_SD;
      end
      ST_EP_SD: begin
        state_nxt = blk_rd ? ST_NOWAY : ST_EP_GD;
      end
      ST_EP_GD: begin
        sweep_nxt = '0;
        state_nxt = blk_rd ? ST_NOWAY : ST_CLR;
      end
      ST_CLR: begin
        wr_addr    = sweep_r;
        req.lab_we = 1'b1;
        sweep_nxt  = sweep_r + AW'(1);
        if (sweep_r == AW'(CELLS - 1)) begin
          state_nxt = ST_SEED;
        end
      end
      ST_SEED: begin
        wr_addr    = cell_addr(sr_r, sc_r);
        req.lab_we = 1'b1;
        req.lab_wd = '0;
        d_nxt      = '0;
        grew_nxt   = 1'b0;
        hit_nxt    = 1'b0;
        if ((sr_r == gr_r) && (sc_r == gc_r)) begin
          len_nxt   = '0;
          td_nxt    = '0;
          r_nxt     = gr_r;
          c_nxt     = gc_r;
          state_nxt = ST_T_STORE;
        end else begin
          r_nxt     = '0;
          c_nxt     = '0;
          state_nxt = ST_W_SELF;
        end
      end
      ST_W_SELF: begin
        state_nxt = ST_W_SELFD;
      end
      ST_W_SELFD: begin
        // only free unlabelled cells can join this layer
        k_nxt = gwsp_pkg::DIR_RIGHT;
        if (blk_rd || (lab_rd != gwsp_pkg::UNLABELLED)) begin
          state_nxt = ST_W_NEXT;
        end else begin
          state_nxt = ST_W_NB;
        end
      end
      ST_W_NB: begin
        if (nb_ok) begin
          state_nxt = ST_W_NBD;
        end else if (k_r == gwsp_pkg::DIR_UP) begin
          state_nxt = ST_W_NEXT;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      ST_W_NBD: begin
        if (lab_rd == LW'(d_r)) begin
          req.lab_we = 1'b1;
          req.lab_wd = LW'(d_r) + LW'(1);
          grew_nxt   = 1'b1;
          if ((r_r == gr_r) && (c_r == gc_r)) begin
            hit_nxt = 1'b1;
          end
          state_nxt = ST_W_NEXT;
        end else if (k_r == gwsp_pkg::DIR_UP) begin
          state_nxt = ST_W_NEXT;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_W_NB;
        end
      end
      ST_W_NEXT: begin
        if ((8'(c_r) + 8'd1) < w8) begin
          c_nxt     = c_r + CWD'(1);
          state_nxt = ST_W_SELF;
        end else if ((8'(r_r) + 8'd1) < h8) begin
          c_nxt     = '0;
          r_nxt     = r_r + RW'(1);
          state_nxt = ST_W_SELF;
        end else if (hit_r) begin
          // goal reached in this layer, trace back from it
          len_nxt   = d_r + SW'(1);
          td_nxt    = d_r + SW'(1);
          r_nxt     = gr_r;
          c_nxt     = gc_r;
          state_nxt = ST_T_STORE;
        end else if (!grew_r || ((7'(d_r) + 7'd1) >= 7'(gwsp_pkg::MAX_STEP))) begin
          state_nxt = ST_NOWAY;
        end else begin
          d_nxt     = d_r + SW'(1);
          grew_nxt  = 1'b0;
          r_nxt     = '0;
          c_nxt     = '0;
          state_nxt = ST_W_SELF;
        end
      end
      ST_T_STORE: begin
        path_we = 1'b1;
        k_nxt   = gwsp_pkg::DIR_RIGHT;
        if (td_r == '0) begin
          i_nxt     = '0;
          state_nxt = ST_E_RD;
        end else begin
          td_nxt    = td_r - SW'(1);
          state_nxt = ST_T_NB;
        end
      end
      ST_T_NB: begin
        if (nb_ok) begin
          state_nxt = ST_T_NBD;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      ST_T_NBD: begin
        if (lab_rd == LW'(td_r)) begin
          r_nxt     = nb_r;
          c_nxt     = nb_c;
          state_nxt = ST_T_STORE;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_T_NB;
        end
      end
      ST_E_RD: begin
        state_nxt = ST_E_OUT;
      end
      ST_E_OUT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_row_nxt     = 3'(p_row);
          out_col_nxt     = 3'(p_col);
          out_step_nxt    = i_r;
          out_outcome_nxt = 1'b0;
          out_last_nxt    = (i_r == len_r);
          if (i_r == len_r) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + SW'(1);
            state_nxt = ST_E_RD;
          end
        end
      end
      ST_NOWAY: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_row_nxt     = '0;
          out_col_nxt     = '0;
          out_step_nxt    = '0;
          out_outcome_nxt = 1'b1;
          out_last_nxt    = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    req.rd_addr = gwsp_pkg::ADDR_W_MAX'(rd_addr);
    req.wr_addr = gwsp_pkg::ADDR_W_MAX'(wr_addr);
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      cols_in_use_r <= 4'd8;
      rows_in_use_r <= 4'd8;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          gwsp_pkg::CFG_COLS: cols_in_use_r <= cfg_wdata;
          gwsp_pkg::CFG_ROWS: rows_in_use_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    r_r           <= r_nxt;
    c_r           <= c_nxt;
    k_r           <= k_nxt;
    d_r           <= d_nxt;
    td_r          <= td_nxt;
    len_r         <= len_nxt;
    i_r           <= i_nxt;
    grew_r        <= grew_nxt;
    hit_r         <= hit_nxt;
    sweep_r       <= sweep_nxt;
    sr_r          <= sr_nxt;
    sc_r          <= sc_nxt;
    gr_r          <= gr_nxt;
    gc_r          <= gc_nxt;
    out_row_r     <= out_row_nxt;
    out_col_r     <= out_col_nxt;
    out_step_r    <= out_step_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_last_r    <= out_last_nxt;
  end

  gwsp_grid_store #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_grid (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .busy  (clr_busy),
    .blk_rd(blk_rd),
    .lab_rd(lab_rd)
  );

  gwsp_path_store #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_path (
    .clk   (clk),
    .wr_en (path_we),
    .wr_idx(td_r),
    .wr_row(r_r),
    .wr_col(c_r),
    .rd_idx(i_r),
    .rd_row(p_row),
    .rd_col(p_col)
  );

  assign out_valid       = out_valid_r;
  assign out_path_row    = out_row_r;
  assign out_path_col    = out_col_r;
  assign out_step_number = out_step_r;
  assign out_outcome     = out_outcome_r;
  assign out_last        = out_last_r;

  // wave never starts a layer beyond the step limit
  a_layer_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_W_SELF) |-> (7'(d_r) < 7'(gwsp_pkg::MAX_STEP)))
    else $error("wave layer past step limit");

  // trace must find a closer neighbour by the last direction
  a_trace_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_T_NB && k_r == gwsp_pkg::DIR_UP) |-> nb_ok)
    else $error("trace ran out of neighbours");

  a_trace_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_T_NBD && k_r == gwsp_pkg::DIR_UP) |-> (lab_rd == LW'(td_r)))
    else $error("trace found no closer cell");

  // a pending non-final path result means emission is still running
  a_emit_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == ST_E_RD || state_r == ST_E_OUT))
    else $error("non-final result outside emission");

  a_clear_closed: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_ready)
    else $error("input taken during map clear");

endmodule
